[rtl/core/prst_pkg.sv]
// Shared types and constants for the outstanding-request statistics table.
// No dependencies; imported by every module of the block.
`default_nettype none

package prst_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int SLOT_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int BEST_SLOT_W = 6;

	// opcodes on the request channel
	localparam logic [1:0] OP_REGISTER = 2'd0;
	localparam logic [1:0] OP_REPLY    = 2'd1;
	localparam logic [1:0] OP_CLEAR    = 2'd2;

	typedef enum logic [1:0] {
		KIND_REG,
		KIND_REPLY,
		KIND_CLEAR,
		KIND_NOP
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] id_high;
		logic [63:0] id_low;
		logic [31:0] now_ms;
		logic [31:0] files;
		logic [31:0] kbytes;
	} item_t;

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] hosts;
		logic [31:0] files;
		logic [31:0] kbytes;
		logic [31:0] delay;
	} stat_t;

	typedef struct packed {
		logic                   found;
		logic [31:0]            entry_hosts;
		logic [31:0]            entry_files;
		logic [31:0]            entry_kbytes;
		logic [31:0]            entry_delay;
		logic                   best_valid;
		logic [BEST_SLOT_W-1:0] best_slot;
		logic [31:0]            best_hosts;
	} rsp_t;

endpackage

`default_nettype wire

[rtl/core/prst_front.sv]
// Front end: accepts request items, classifies the opcode and queues them.
// Depends on prst_pkg.
`default_nettype none

module prst_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  logic [1:0]      op,
	input  logic [63:0]     id_high,
	input  logic [63:0]     id_low,
	input  logic [31:0]     now_ms,
	input  logic [31:0]     files_reported,
	input  logic [31:0]     kbytes_reported,
	output logic            q_valid,
	output prst_pkg::item_t q_item,
	input  logic            q_pop
);
	import prst_pkg::*;

	item_t             fifo_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;
	logic              push;
	logic              pop;
	item_t             new_item;

	always_comb begin
		new_item.id_high = id_high;
		new_item.id_low  = id_low;
		new_item.now_ms  = now_ms;
		new_item.files   = files_reported;
		new_item.kbytes  = kbytes_reported;
		case (op)
			OP_REGISTER: new_item.kind = KIND_REG;
			OP_REPLY:    new_item.kind = KIND_REPLY;
			OP_CLEAR:    new_item.kind = KIND_CLEAR;
			default:     new_item.kind = KIND_NOP;
		endcase
	end

	assign req_stall = (fill_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign push      = req_valid & ~req_stall;
	assign q_valid   = (fill_q != '0);
	assign pop       = q_pop & q_valid;
	assign q_item    = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      fill_q <= fill_q + 1'b1;
			else if (pop && !push) fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= new_item;
	end

endmodule

`default_nettype wire

[rtl/core/prst_back.sv]
// Back end: table memories, newest-first id search, counter update and
// result register. Depends on prst_pkg.
`default_nettype none

module prst_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  prst_pkg::item_t q_item,
	output logic            q_pop,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output prst_pkg::rsp_t  rsp
);
	import prst_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_EXEC   = 2'd1;
	localparam logic [1:0] S_SEARCH = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	logic [127:0] key_mem  [TABLE_DEPTH];
	stat_t        stat_mem [TABLE_DEPTH];

	logic [1:0]        state_q;
	item_t             it_q;
	logic [SLOT_W-1:0] ws_q;
	logic [CNT_W-1:0]  count_q;
	logic              best_set_q;
	logic [SLOT_W-1:0] best_idx_q;
	logic [31:0]       best_hosts_q;
	logic [SLOT_W-1:0] rd_addr_q;
	logic [CNT_W-1:0]  left_q;
	logic              cmp_valid_s1;
	logic              cmp_last_s1;
	logic [SLOT_W-1:0] cmp_slot_s1;
	logic [127:0]      key_rd_s1;
	stat_t             stat_rd_s1;
	logic              res_found_q;
	stat_t             res_stat_q;
	rsp_t              out_q;
	logic              out_valid_q;

	logic              key_we;
	logic              stat_we;
	logic [SLOT_W-1:0] stat_waddr;
	stat_t             stat_wdata;
	stat_t             upd;
	stat_t             fresh;
	logic              hit;
	logic              best_take;
	logic              out_free;
	logic              finish;

	function automatic logic [SLOT_W-1:0] slot_prev(input logic [SLOT_W-1:0] s);
		return (s == '0) ? SLOT_W'(TABLE_DEPTH - 1) : s - 1'b1;
	endfunction

	function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(TABLE_DEPTH - 1)) ? '0 : s + 1'b1;
	endfunction

	assign q_pop = (state_q == S_IDLE);

	// compare stage: read data of the slot issued last cycle
	assign hit = (state_q == S_SEARCH) && cmp_valid_s1 &&
		(key_rd_s1 == {it_q.id_high, it_q.id_low});

	always_comb begin
		upd.start  = stat_rd_s1.start;
		upd.hosts  = stat_rd_s1.hosts + 32'd1;
		upd.files  = stat_rd_s1.files + it_q.files;
		upd.kbytes = stat_rd_s1.kbytes + it_q.kbytes;
		upd.delay  = stat_rd_s1.delay + (it_q.now_ms - stat_rd_s1.start);
		fresh.start  = it_q.now_ms;
		fresh.hosts  = '0;
		fresh.files  = '0;
		fresh.kbytes = '0;
		fresh.delay  = '0;
	end

	// same slot as best: the best record follows that slot's count
	assign best_take = !best_set_q || (upd.hosts > best_hosts_q) ||
		(cmp_slot_s1 == best_idx_q);

	assign key_we     = (state_q == S_EXEC) && (it_q.kind == KIND_REG);
	assign stat_we    = key_we || hit;
	assign stat_waddr = hit ? cmp_slot_s1 : ws_q;
	assign stat_wdata = hit ? upd : fresh;

	always_ff @(posedge clk) begin
		if (key_we)  key_mem[ws_q] <= {it_q.id_high, it_q.id_low};
		if (stat_we) stat_mem[stat_waddr] <= stat_wdata;
		key_rd_s1  <= key_mem[rd_addr_q];
		stat_rd_s1 <= stat_mem[rd_addr_q];
	end

	assign out_free = !out_valid_q || !rsp_stall;
	assign finish   = (state_q == S_FINISH) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ws_q         <= '0;
			count_q      <= '0;
			best_set_q   <= 1'b0;
			best_idx_q   <= '0;
			best_hosts_q <= '0;
			rd_addr_q    <= '0;
			left_q       <= '0;
			cmp_valid_s1 <= 1'b0;
			cmp_last_s1  <= 1'b0;
			cmp_slot_s1  <= '0;
			res_found_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			cmp_valid_s1 <= (state_q == S_SEARCH) && (left_q != '0) && !hit;
			cmp_last_s1  <= (left_q == CNT_W'(1));
			cmp_slot_s1  <= rd_addr_q;

			if (out_valid_q && !rsp_stall && !finish) out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (q_valid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					res_found_q <= 1'b0;
					case (it_q.kind)
						KIND_REG: begin
							state_q <= S_FINISH;
							ws_q    <= slot_next(ws_q);
							if (count_q != CNT_W'(TABLE_DEPTH)) count_q <= count_q + 1'b1;
							if (best_set_q && (best_idx_q == ws_q)) best_hosts_q <= '0;
						end
						KIND_REPLY: begin
							if (count_q != '0) begin
								rd_addr_q <= slot_prev(ws_q);
								left_q    <= count_q;
								state_q   <= S_SEARCH;
							end else begin
								state_q <= S_FINISH;
							end
						end
						KIND_CLEAR: begin
							state_q      <= S_FINISH;
							ws_q         <= '0;
							count_q      <= '0;
							best_set_q   <= 1'b0;
							best_idx_q   <= '0;
							best_hosts_q <= '0;
						end
						default: begin
							state_q <= S_FINISH;
						end
					endcase
				end
				S_SEARCH: begin
					if (left_q != '0) begin
						rd_addr_q <= slot_prev(rd_addr_q);
						left_q    <= left_q - 1'b1;
					end
					if (hit) begin
						res_found_q <= 1'b1;
						if (best_take) begin
							best_set_q   <= 1'b1;
							best_idx_q   <= cmp_slot_s1;
							best_hosts_q <= upd.hosts;
						end
						state_q <= S_FINISH;
					end else if (cmp_valid_s1 && cmp_last_s1) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && q_valid) it_q <= q_item;
		if (hit) res_stat_q <= upd;
		if (finish) begin
			out_q.found        <= res_found_q;
			out_q.entry_hosts  <= res_found_q ? res_stat_q.hosts  : '0;
			out_q.entry_files  <= res_found_q ? res_stat_q.files  : '0;
			out_q.entry_kbytes <= res_found_q ? res_stat_q.kbytes : '0;
			out_q.entry_delay  <= res_found_q ? res_stat_q.delay  : '0;
			out_q.best_valid   <= best_set_q;
			out_q.best_slot    <= best_set_q ? BEST_SLOT_W'(best_idx_q) : '0;
			out_q.best_hosts   <= best_set_q ? best_hosts_q : '0;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

`default_nettype wire

[rtl/core/ping_reply_stats_table.sv]
// Outstanding-request statistics table, top level. Uses prst_pkg, prst_front, prst_back.
// Flow: each accepted item is queued, then the back end loads it, executes it and
// registers its result; a reply first searches the stored entries, newest first.
// Back end: one item at a time; the id search over the single key memory read
// port sets how long a reply takes.
// Reset: control state clears at once; table memories are not cleared (empty table).
`default_nettype none

module ping_reply_stats_table (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  op,
	input  logic [63:0] id_high,
	input  logic [63:0] id_low,
	input  logic [31:0] now_ms,
	input  logic [31:0] files_reported,
	input  logic [31:0] kbytes_reported,
	// result channel
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic        found,
	output logic [31:0] entry_hosts,
	output logic [31:0] entry_files,
	output logic [31:0] entry_kbytes,
	output logic [31:0] entry_delay,
	output logic        best_valid,
	output logic [5:0]  best_slot,
	output logic [31:0] best_hosts
);
	import prst_pkg::*;

	// queue between front and back
	logic  q_valid;
	logic  q_pop;
	item_t q_item;
	rsp_t  rsp;

	// Front: classifies each item and holds up to four in a queue, so the
	// sender only sees stall when the back end falls four items behind.
	prst_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.op              (op),
		.id_high         (id_high),
		.id_low          (id_low),
		.now_ms          (now_ms),
		.files_reported  (files_reported),
		.kbytes_reported (kbytes_reported),
		.q_valid         (q_valid),
		.q_item          (q_item),
		.q_pop           (q_pop)
	);

	// Back: owns the table. A reply walks stored slots newest first, one
	// read per cycle, and on the first id match updates that slot's
	// counters and the most-hosts record in the same cycle. The result sits
	// in an output register so the back end can stall on its own.
	prst_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	assign found        = rsp.found;
	assign entry_hosts  = rsp.entry_hosts;
	assign entry_files  = rsp.entry_files;
	assign entry_kbytes = rsp.entry_kbytes;
	assign entry_delay  = rsp.entry_delay;
	assign best_valid   = rsp.best_valid;
	assign best_slot    = rsp.best_slot;
	assign best_hosts   = rsp.best_hosts;

endmodule

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for ping_reply_stats_table: a directed table, then random traffic.
// Depends on prst_pkg and the RTL top; each result is predicted or given, checked by field.

module tb;
	import prst_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;	// undefined code: leaves the table as it is, but still gives a result
	localparam int RANDOM_ITEMS = 1500;
	localparam int IDLE_LIMIT   = 2000;	// cycles with no handshake on either side
	localparam int DRAIN_CYCLES = 100;	// a reply may search the whole table
	localparam int MAX_STALL    = 12;
	localparam int MAX_GAP      = 20;

	typedef struct {
		logic [1:0]  code;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [31:0] stamp;
		logic [31:0] files;
		logic [31:0] kb;
		bit          typed;
		rsp_t        want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [1:0]  op = OP_REGISTER;
	logic [63:0] id_high = '0;
	logic [63:0] id_low = '0;
	logic [31:0] now_ms = '0;
	logic [31:0] files_reported = '0;
	logic [31:0] kbytes_reported = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic        found;
	logic [31:0] entry_hosts;
	logic [31:0] entry_files;
	logic [31:0] entry_kbytes;
	logic [31:0] entry_delay;
	logic        best_valid;
	logic [5:0]  best_slot;
	logic [31:0] best_hosts;

	ping_reply_stats_table dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted copy of the request table
	logic [63:0] slot_id_hi  [TABLE_DEPTH];
	logic [63:0] slot_id_lo  [TABLE_DEPTH];
	logic [31:0] slot_start  [TABLE_DEPTH];
	logic [31:0] slot_hosts  [TABLE_DEPTH];
	logic [31:0] slot_files  [TABLE_DEPTH];
	logic [31:0] slot_kbytes [TABLE_DEPTH];
	logic [31:0] slot_delay  [TABLE_DEPTH];
	int          live_count = 0;
	int          next_slot = 0;
	bit          best_set = 1'b0;
	int          best_at = 0;

	rsp_t     pending_results[$];
	dir_row_t dir_rows[$];
	int       error_count = 0;
	int       burst_left = 0;
	int       idle_cycles = 0;
	int       stall_mode = 0;
	int       mode_left = 0;
	int       stall_run = 0;

	task automatic log_error(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	task automatic cmp_field(input string name, input logic [63:0] got, input logic [63:0] want);
		if (got !== want)
			log_error($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	function automatic rsp_t mk_rsp(input bit f, input logic [31:0] h, input logic [31:0] fl,
			input logic [31:0] k, input logic [31:0] d, input bit bv, input logic [5:0] bs,
			input logic [31:0] bh);
		rsp_t r;
		r.found = f;
		r.entry_hosts = h;
		r.entry_files = fl;
		r.entry_kbytes = k;
		r.entry_delay = d;
		r.best_valid = bv;
		r.best_slot = bs;
		r.best_hosts = bh;
		return r;
	endfunction

	// Applies one item to the predicted table and returns the result it causes.
	function automatic rsp_t update_table_stats(input logic [1:0] code, input logic [63:0] hi,
			input logic [63:0] lo, input logic [31:0] stamp, input logic [31:0] files,
			input logic [31:0] kb);
		rsp_t res;
		int   hit;
		int   k;
		int   s;
		res = '0;
		hit = -1;
		case (code)
			OP_REGISTER: begin
				slot_id_hi[next_slot] = hi;
				slot_id_lo[next_slot] = lo;
				slot_start[next_slot] = stamp;
				slot_hosts[next_slot] = '0;
				slot_files[next_slot] = '0;
				slot_kbytes[next_slot] = '0;
				slot_delay[next_slot] = '0;
				next_slot = (next_slot + 1) % TABLE_DEPTH;
				if (live_count < TABLE_DEPTH)
					live_count++;
			end
			OP_REPLY: begin
				// newest entry first
				for (k = 1; k <= live_count && hit < 0; k++) begin
					s = (next_slot + TABLE_DEPTH - k) % TABLE_DEPTH;
					if (slot_id_hi[s] == hi && slot_id_lo[s] == lo)
						hit = s;
				end
				if (hit >= 0) begin
					slot_hosts[hit] += 32'd1;
					slot_files[hit] += files;
					slot_kbytes[hit] += kb;
					slot_delay[hit] += stamp - slot_start[hit];
					// a tie does not move the best entry
					if (!best_set || slot_hosts[hit] > slot_hosts[best_at]) begin
						best_set = 1'b1;
						best_at = hit;
					end
					res.found = 1'b1;
					res.entry_hosts = slot_hosts[hit];
					res.entry_files = slot_files[hit];
					res.entry_kbytes = slot_kbytes[hit];
					res.entry_delay = slot_delay[hit];
				end
			end
			OP_CLEAR: begin
				live_count = 0;
				next_slot = 0;
				best_set = 1'b0;
				best_at = 0;
			end
			default: ;
		endcase
		// best slot may have been reused by a register item: it reads the new count
		res.best_valid = best_set;
		res.best_slot = best_set ? best_at[5:0] : 6'd0;
		res.best_hosts = best_set ? slot_hosts[best_at] : 32'd0;
		return res;
	endfunction

	function automatic void add_row(input logic [1:0] code, input logic [63:0] hi,
			input logic [63:0] lo, input logic [31:0] stamp, input logic [31:0] files,
			input logic [31:0] kb, input bit typed, input rsp_t want);
		dir_row_t r;
		r.code = code;
		r.hi = hi;
		r.lo = lo;
		r.stamp = stamp;
		r.files = files;
		r.kb = kb;
		r.typed = typed;
		r.want = want;
		dir_rows.push_back(r);
	endfunction

	// Presents one item, waits for acceptance, records its expected result; a burst ends in a gap.
	task automatic send_item(input logic [1:0] code, input logic [63:0] hi, input logic [63:0] lo,
			input logic [31:0] stamp, input logic [31:0] files, input logic [31:0] kb,
			input bit typed, input rsp_t want);
		rsp_t predicted;
		req_valid <= 1'b1;
		op <= code;
		id_high <= hi;
		id_low <= lo;
		now_ms <= stamp;
		files_reported <= files;
		kbytes_reported <= kb;
		do @(posedge clk); while (req_stall !== 1'b0);
		predicted = update_table_stats(code, hi, lo, stamp, files, kb);
		pending_results.push_back(typed ? want : predicted);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
			// mostly short bursts, now and then a long stretch with no gaps
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 30);
		end
	endtask

	// pick the id of a live entry, biased toward the newest ones
	function automatic int live_slot();
		int k;
		if ($urandom_range(0, 1) == 0)
			k = $urandom_range(1, (live_count < 8) ? live_count : 8);
		else
			k = $urandom_range(1, live_count);
		return (next_slot + TABLE_DEPTH - k) % TABLE_DEPTH;
	endfunction

	// result side: check each accepted result, then choose the next stall
	always @(posedge clk) begin
		rsp_t exp_r;
		if (arst_n && $isunknown(rsp_valid))
			log_error("rsp_valid unknown");
		if (arst_n && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
			if (pending_results.size() == 0) begin
				log_error("result with none expected");
			end else begin
				exp_r = pending_results.pop_front();
				cmp_field("found", found, exp_r.found);
				cmp_field("entry_hosts", entry_hosts, exp_r.entry_hosts);
				cmp_field("entry_files", entry_files, exp_r.entry_files);
				cmp_field("entry_kbytes", entry_kbytes, exp_r.entry_kbytes);
				cmp_field("entry_delay", entry_delay, exp_r.entry_delay);
				cmp_field("best_valid", best_valid, exp_r.best_valid);
				cmp_field("best_slot", best_slot, exp_r.best_slot);
				cmp_field("best_hosts", best_hosts, exp_r.best_hosts);
			end
		end
		// modes: no stall, light stall, heavy stall; runs are capped
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			mode_left = $urandom_range(50, 300);
		end
		mode_left--;
		if (stall_run >= MAX_STALL || stall_mode == 0)
			stall_run = 0;
		else if ($urandom_range(0, 99) < ((stall_mode == 1) ? 25 : 75))
			stall_run++;
		else
			stall_run = 0;
		rsp_stall <= (stall_run != 0);
	end

	// watchdog: too long with nothing accepted on either side
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("** ping_reply_stats_table: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [63:0] all1;
		logic [1:0]  code;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [31:0] stamp;
		logic [31:0] clock_ms;
		logic [31:0] files;
		logic [31:0] kb;
		int          counted;
		int          r;
		int          s;
		rsp_t        none;

		all1 = '1;
		none = '0;
		clock_ms = 32'hFFFF_0000;	// wraps early in the run
		counted = 0;
		burst_left = $urandom_range(1, 30);

		// directed: empty table, unused code, wrap of sums and delay, duplicates, ties, clear
		add_row(OP_REPLY, all1, all1, '1, '1, '1, 1, none);
		add_row(OP_UNUSED, all1, all1, '1, '1, '1, 1, none);
		add_row(OP_CLEAR, all1, all1, '1, '1, '1, 1, none);
		add_row(OP_REGISTER, all1, all1, 32'hFFFF_FFF0, '0, '0, 1, none);
		add_row(OP_REPLY, all1, all1, 32'h10, '1, '1, 1,
			mk_rsp(1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h20, 1, 0, 1));
		add_row(OP_REPLY, all1, all1, 32'h10, 32'd1, 32'd2, 1,
			mk_rsp(1, 2, 0, 1, 32'h40, 1, 0, 2));
		add_row(OP_REGISTER, '0, '0, '0, '1, '1, 0, none);
		add_row(OP_REGISTER, all1, all1, 32'h1000, '0, '0, 0, none);	// duplicate id
		add_row(OP_REPLY, all1, all1, 32'h1100, 32'd5, 32'd7, 0, none);
		add_row(OP_REPLY, all1, all1, 32'h1200, 32'd5, 32'd7, 0, none);	// tie with best
		add_row(OP_REPLY, all1, all1, 32'h1300, 32'd5, 32'd7, 0, none);	// best moves
		add_row(OP_REPLY, '0, '0, '1, '0, '0, 0, none);
		add_row(OP_REPLY, all1, '0, 32'h1400, 32'd1, 32'd1, 0, none);	// half match only
		add_row(OP_REGISTER, '0, all1, 32'h8000_0000, '0, '0, 0, none);
		add_row(OP_REPLY, '0, all1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0, none);
		add_row(OP_UNUSED, '0, '0, '0, '0, '0, 0, none);
		add_row(OP_CLEAR, '0, '0, '0, '0, '0, 1, none);
		add_row(OP_REPLY, all1, all1, 32'h2000, 32'd1, 32'd1, 1, none);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].code, dir_rows[i].hi, dir_rows[i].lo, dir_rows[i].stamp,
				dir_rows[i].files, dir_rows[i].kb, dir_rows[i].typed, dir_rows[i].want);

		// random: mostly registers and replies that hit live ids; clears are rare so
		// the table fills, wraps and reuses the best slot
		while (counted < RANDOM_ITEMS) begin
			r = $urandom_range(0, 999);
			clock_ms += $urandom_range(0, 3000);
			stamp = ($urandom_range(0, 15) == 0) ? $urandom : clock_ms;
			files = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 500);
			kb = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 5000);
			hi = {$urandom, $urandom};
			lo = {$urandom, $urandom};
			if (r < 5) begin
				code = OP_CLEAR;
			end else if (r < 35) begin
				code = OP_UNUSED;
			end else if (r < 480) begin
				code = OP_REGISTER;
				if (live_count > 0 && $urandom_range(0, 3) == 0) begin
					s = live_slot();
					hi = slot_id_hi[s];
					lo = slot_id_lo[s];
				end
			end else begin
				code = OP_REPLY;
				if (live_count > 0 && $urandom_range(0, 9) < 8) begin
					s = live_slot();
					hi = slot_id_hi[s];
					lo = slot_id_lo[s];
					// now and then only one half of the id matches
					if ($urandom_range(0, 19) == 0)
						lo[$urandom_range(0, 63)] ^= 1'b1;
				end
			end
			if (code != OP_UNUSED)
				counted++;
			send_item(code, hi, lo, stamp, files, kb, 0, none);
		end
		req_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("** ping_reply_stats_table: PASSED **");
		else
			$display("** ping_reply_stats_table: FAILED **");
		$finish;
	end

endmodule
